[rtl/sse_pkg.sv]
// Shared types and constants for the sorted set engine.
package sse_pkg;

	localparam int CAPACITY = 64;
	localparam int KEY_BITS = 16;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int FUNC_W   = 2;
	localparam int IN_KEY_W = 16;
	localparam int STAT_W   = 2;
	localparam int OCC_W    = 7;

	typedef logic [KEY_BITS-1:0] key_t;
	typedef logic [CNT_W-1:0]    cnt_t;

	typedef enum logic [FUNC_W-1:0] {
		FN_MEMBER = 2'd0,
		FN_INSERT = 2'd1,
		FN_DELETE = 2'd2
	} func_t;

	typedef enum logic [STAT_W-1:0] {
		ST_NOT_DONE = 2'd0,
		ST_DONE     = 2'd1,
		ST_FULL     = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_CMP,
		PH_EXEC
	} phase_t;

	typedef struct packed {
		logic cmp;
		logic ins;
		logic del;
		key_t key;
	} cell_ctl_t;

endpackage

[rtl/sorted_set_engine_core.sv]
// Sorted set engine top level: command control, count and a chain of key cells.
// Result strobe (done) is registered: a taken start beat moves the sequencer to compare, then execute,
// and done rises after execute. busy is high for the compare cycle only,
//   and the chain updates in the following cycle while the next start may be taken.
// Reset: arst_n clears the key count, the sequencer and done; cell keys are not reset.
// The receiver cannot stall: done is high for one cycle only per result.
module sorted_set_engine_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [sse_pkg::FUNC_W-1:0]    func,
	input  logic [sse_pkg::IN_KEY_W-1:0]  key,
	output logic                          done,
	output logic [sse_pkg::STAT_W-1:0]    status,
	output logic [sse_pkg::OCC_W-1:0]     occupancy
);

	sse_pkg::phase_t    phase_q;
	sse_pkg::phase_t    phase_d;
	logic               accept;
	logic [sse_pkg::FUNC_W-1:0] func_q;
	sse_pkg::key_t      key_q;
	sse_pkg::cnt_t      count_q;
	logic               done_q;
	sse_pkg::status_t   status_q;
	sse_pkg::status_t   status_d;
	logic               present;
	logic               do_ins;
	logic               do_del;
	sse_pkg::cell_ctl_t ctl;

	sse_pkg::key_t      cell_keys [sse_pkg::CAPACITY];
	logic [sse_pkg::CAPACITY-1:0] lt_vec;
	logic [sse_pkg::CAPACITY-1:0] eq_vec;

	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= sse_pkg::PH_IDLE;
		end else begin
			phase_q <= phase_d;
		end
	end

	always_comb begin
		busy    = 1'b0;
		phase_d = sse_pkg::PH_IDLE;
		case (phase_q)
			sse_pkg::PH_CMP: begin
				busy    = 1'b1;
				phase_d = sse_pkg::PH_EXEC;
			end
			sse_pkg::PH_IDLE, sse_pkg::PH_EXEC: begin
				phase_d = start ? sse_pkg::PH_CMP : sse_pkg::PH_IDLE;
			end
			default: phase_d = sse_pkg::PH_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func;
			key_q  <= sse_pkg::KEY_BITS'(key);
		end
	end

	assign present = |eq_vec;

	always_comb begin
		do_ins   = 1'b0;
		do_del   = 1'b0;
		status_d = sse_pkg::ST_NOT_DONE;
		if (phase_q == sse_pkg::PH_EXEC) begin
			case (func_q)
				sse_pkg::FN_MEMBER: begin
					status_d = present ? sse_pkg::ST_DONE : sse_pkg::ST_NOT_DONE;
				end
				sse_pkg::FN_INSERT: begin
					if (present) begin
						status_d = sse_pkg::ST_NOT_DONE;
					end else if (count_q >= sse_pkg::CNT_W'(sse_pkg::CAPACITY)) begin
						status_d = sse_pkg::ST_FULL;
					end else begin
						do_ins   = 1'b1;
						status_d = sse_pkg::ST_DONE;
					end
				end
				sse_pkg::FN_DELETE: begin
					if (present) begin
						do_del   = 1'b1;
						status_d = sse_pkg::ST_DONE;
					end
				end
				default: status_d = sse_pkg::ST_NOT_DONE;
			endcase
		end
	end

	assign ctl.cmp = (phase_q == sse_pkg::PH_CMP);
	assign ctl.ins = do_ins;
	assign ctl.del = do_del;
	assign ctl.key = key_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (phase_q == sse_pkg::PH_EXEC);
			if (do_ins) begin
				count_q <= count_q + sse_pkg::CNT_W'(1);
			end else if (do_del) begin
				count_q <= count_q - sse_pkg::CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (phase_q == sse_pkg::PH_EXEC) begin
			status_q <= status_d;
		end
	end

	genvar gi;
	generate
		for (gi = 0; gi < sse_pkg::CAPACITY; gi++) begin : g_cell
			logic          occ;
			logic          left_lt;
			sse_pkg::key_t left_key;
			sse_pkg::key_t right_key;

			assign occ = (sse_pkg::CNT_W'(gi) < count_q);

			if (gi == 0) begin : g_first
				assign left_lt  = 1'b1;
				assign left_key = key_q;
			end else begin : g_mid
				assign left_lt  = lt_vec[gi-1];
				assign left_key = cell_keys[gi-1];
			end

			if (gi == sse_pkg::CAPACITY - 1) begin : g_last
				assign right_key = cell_keys[gi];
			end else begin : g_inner
				assign right_key = cell_keys[gi+1];
			end

			sse_cell u_cell (
				.clk       (clk),
				.ctl       (ctl),
				.occ       (occ),
				.left_lt   (left_lt),
				.left_key  (left_key),
				.right_key (right_key),
				.cell_key  (cell_keys[gi]),
				.lt        (lt_vec[gi]),
				.eq        (eq_vec[gi])
			);
		end
	endgenerate

	assign done      = done_q;
	assign status    = status_q;
	assign occupancy = sse_pkg::OCC_W'(count_q);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= sse_pkg::CNT_W'(sse_pkg::CAPACITY))
		else $error("key count above capacity");

	a_done_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == sse_pkg::PH_EXEC) |=> done)
		else $error("no result beat after execute cycle");

	a_one_shift: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({do_ins, do_del}))
		else $error("insert and delete shift at once");

	a_full_refusal: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == sse_pkg::ST_FULL) |-> count_q == sse_pkg::CNT_W'(sse_pkg::CAPACITY))
		else $error("full refusal with room left");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != sse_pkg::PH_EXEC) |=> $stable(count_q))
		else $error("count changed outside execute cycle");

endmodule

[rtl/sse_cell.sv]
// One storage cell of the sorted key chain: compare, shift up on insert, shift down on delete.
module sse_cell (
	input  logic                  clk,
	input  sse_pkg::cell_ctl_t    ctl,
	input  logic                  occ,
	input  logic                  left_lt,
	input  sse_pkg::key_t         left_key,
	input  sse_pkg::key_t         right_key,
	output sse_pkg::key_t         cell_key,
	output logic                  lt,
	output logic                  eq
);

	sse_pkg::key_t key_q;
	logic          lt_q;
	logic          eq_q;

	always_ff @(posedge clk) begin
		if (ctl.cmp) begin
			lt_q <= occ && (key_q < ctl.key);
			eq_q <= occ && (key_q == ctl.key);
		end
		if (ctl.ins && !lt_q) begin
			key_q <= left_lt ? ctl.key : left_key;
		end else if (ctl.del && !lt_q) begin
			key_q <= right_key;
		end
	end

	assign cell_key = key_q;
	assign lt       = lt_q;
	assign eq       = eq_q;

endmodule
